FILE: rtl/sttl_pkg.sv
package sttl_pkg;

    localparam int TABLE_ENTRIES = 128;
    localparam int SLOT_W        = 7;

    localparam logic [15:0] ETH_IPV4  = 16'h0800;
    localparam logic [15:0] ETH_IPV6  = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  V6_TCP_START = 8'd54;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic [2:0] RSN_NOT_TCPIP = 3'd0;
    localparam logic [2:0] RSN_NOT_SYNACK = 3'd1;
    localparam logic [2:0] RSN_NO_MATCH  = 3'd2;
    localparam logic [2:0] RSN_RECORDED  = 3'd3;
    localparam logic [2:0] RSN_BAD_IHL   = 3'd4;
    localparam logic [2:0] RSN_TABLE_OP  = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } t_state;

    // token passed along the cell chain during a frame lookup
    typedef struct packed {
        logic                 active;
        logic                 found;
        logic [SLOT_W-1:0]    slot;
    } t_tok;

    // command broadcast to every cell
    typedef struct packed {
        logic                 wr;
        logic [SLOT_W-1:0]    wr_slot;
        logic                 wr_valid;
        logic [63:0]          wr_high;
        logic [63:0]          wr_low;
        logic [15:0]          wr_port;
        logic                 rec;
        logic [SLOT_W-1:0]    rec_slot;
        logic [7:0]           rec_ttl;
        logic [63:0]          key_high;
        logic [63:0]          key_low;
        logic [15:0]          key_port;
    } t_cmd;

endpackage

FILE: rtl/sttl_cell.sv
module sttl_cell
    import sttl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SLOT_W-1:0] i_index,
    input  t_cmd              i_cmd,
    input  t_tok              i_tok,
    output t_tok              o_tok,
    output logic              o_valid,
    output logic [7:0]        o_ttl
);
    logic        r_valid;
    logic [63:0] r_high;
    logic [63:0] r_low;
    logic [15:0] r_port;
    logic [7:0]  r_ttl;
    logic        w_match;
    t_tok        r_tok;

    assign w_match = r_valid && r_high == i_cmd.key_high && r_low == i_cmd.key_low
                     && r_port == i_cmd.key_port;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_tok.active <= i_tok.active;
            if (i_tok.active && !i_tok.found && w_match) begin
                r_tok.found <= 1'b1;
                r_tok.slot  <= i_index;
            end else begin
                r_tok.found <= i_tok.found;
                r_tok.slot  <= i_tok.slot;
            end
            if (i_cmd.wr && i_cmd.wr_slot == i_index) begin
                r_valid <= i_cmd.wr_valid;
            end
        end
        if (i_cmd.wr && i_cmd.wr_slot == i_index) begin
            r_high <= i_cmd.wr_high;
            r_low  <= i_cmd.wr_low;
            r_port <= i_cmd.wr_port;
            r_ttl  <= 8'd0;
        end else if (i_cmd.rec && i_cmd.rec_slot == i_index) begin
            r_ttl <= i_cmd.rec_ttl;
        end
    end

    assign o_tok   = r_tok;
    assign o_valid = r_valid;
    assign o_ttl   = r_ttl;
endmodule

FILE: rtl/sttl_parser.sv
module sttl_parser
    import sttl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    output logic [15:0] o_etype,
    output logic [3:0]  o_ihl,
    output logic [7:0]  o_proto,
    output logic [7:0]  o_hop,
    output logic [63:0] o_high,
    output logic [63:0] o_low,
    output logic [15:0] o_port,
    output logic [7:0]  o_flags
);
    logic [7:0]  r_pos;
    logic [15:0] r_etype;
    logic [3:0]  r_ihl;
    logic [7:0]  r_proto, r_hop, r_flags;
    logic [63:0] r_high, r_low;
    logic [15:0] r_port;

    logic [15:0] n_etype;
    logic [3:0]  n_ihl;
    logic [7:0]  n_proto, n_hop, n_flags;
    logic [63:0] n_high, n_low;
    logic [15:0] n_port;
    logic [8:0]  w_tstart;
    logic        w_tcp;
    logic [8:0]  w_off;

    always_comb begin
        n_etype = r_etype; n_ihl = r_ihl; n_proto = r_proto; n_hop = r_hop;
        n_high = r_high; n_low = r_low; n_port = r_port; n_flags = r_flags;
        w_tstart = '0; w_tcp = 1'b0; w_off = '0;
        if (r_pos == 8'd12) n_etype = {i_byte, 8'h00};
        if (r_pos == 8'd13) n_etype = {r_etype[15:8], i_byte};
        if (n_etype == ETH_IPV4 && r_pos >= 8'd14) begin
            if (r_pos == 8'd14) n_ihl = i_byte[3:0];
            if (r_pos == 8'd22) n_hop = i_byte;
            if (r_pos == 8'd23) n_proto = i_byte;
            if (r_pos >= 8'd26 && r_pos <= 8'd29)
                n_low[8*2'(2'd1 - r_pos[1:0]) +: 8] = i_byte;
            if (r_pos > 8'd14 && r_ihl >= 4'd5) begin
                w_tstart = 9'd14 + {3'd0, r_ihl, 2'b00};
                w_tcp = 1'b1;
            end
        end else if (n_etype == ETH_IPV6 && r_pos >= 8'd14) begin
            if (r_pos == 8'd20) n_proto = i_byte;
            if (r_pos == 8'd21) n_hop = i_byte;
            if (r_pos >= 8'd22 && r_pos <= 8'd29)
                n_high[8*(3'd7 - 3'(r_pos - 8'd22)) +: 8] = i_byte;
            if (r_pos >= 8'd30 && r_pos <= 8'd37)
                n_low[8*(3'd7 - 3'(r_pos - 8'd30)) +: 8] = i_byte;
            w_tstart = {1'b0, V6_TCP_START};
            w_tcp = 1'b1;
        end
        if (w_tcp && {1'b0, r_pos} >= w_tstart) begin
            w_off = {1'b0, r_pos} - w_tstart;
            if (w_off == 9'd0) n_port = {i_byte, 8'h00};
            if (w_off == 9'd1) n_port = {r_port[15:8], i_byte};
            if (w_off == 9'd13) n_flags = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_pos <= '0; r_etype <= '0; r_ihl <= '0; r_proto <= '0; r_hop <= '0;
            r_high <= '0; r_low <= '0; r_port <= '0; r_flags <= '0;
        end else if (i_en) begin
            if (r_pos != 8'd255) r_pos <= r_pos + 8'd1;
            r_etype <= n_etype; r_ihl <= n_ihl; r_proto <= n_proto; r_hop <= n_hop;
            r_high <= n_high; r_low <= n_low; r_port <= n_port; r_flags <= n_flags;
        end
    end

    // the last byte's fields are seen combinationally for the verdict
    assign o_etype = n_etype;
    assign o_ihl   = n_ihl;
    assign o_proto = n_proto;
    assign o_hop   = n_hop;
    assign o_high  = n_high;
    assign o_low   = n_low;
    assign o_port  = n_port;
    assign o_flags = n_flags;
endmodule

FILE: rtl/synack_ttl_flow_recorder_unit.sv
// Channel  | Ports                                              | Direction
// command  | start, i_op, i_data_byte, i_last_byte, i_slot; busy is out | in
//          | i_addr_high, i_addr_low, i_port, i_install         |
// result   | o_strobe, o_drop, o_reason, o_hit_slot, o_ttl,      | out
//          | o_entry_valid                                      |
// A frame byte raises busy only if it is a last byte that needs a lookup; a
// last byte that needs no lookup shows its verdict in the cycle after the
// accepting edge. A table op is registered in r_tbl_pend, then in the result
// registers; r_tbl_pend keeps busy high for one cycle, holding the next
// transfer off. A lookup runs the key through the chain of TABLE_ENTRIES
// cells, one per cycle; its verdict is registered when the search count
// reaches TABLE_ENTRIES; busy holds the next transfer off through the search.
// Reset is synchronous, active low, and clears the valid bits.
// The receiver cannot stall: each result shows for one cycle on o_strobe.
module synack_ttl_flow_recorder_unit
    import sttl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_op,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    input  logic [6:0]        i_slot,
    input  logic [63:0]       i_addr_high,
    input  logic [63:0]       i_addr_low,
    input  logic [15:0]       i_port,
    input  logic              i_install,
    output logic              o_strobe,
    output logic              o_drop,
    output logic [2:0]        o_reason,
    output logic [6:0]        o_hit_slot,
    output logic [7:0]        o_ttl,
    output logic              o_entry_valid
);
    t_state r_state, n_state;
    logic   w_acc;
    t_op    w_op;

    logic [15:0] p_etype, p_port;
    logic [3:0]  p_ihl;
    logic [7:0]  p_proto, p_hop, p_flags;
    logic [63:0] p_high, p_low;

    t_cmd r_cmd;
    t_tok w_tok [TABLE_ENTRIES+1];
    logic w_cv  [TABLE_ENTRIES];
    logic [7:0] w_ct [TABLE_ENTRIES];
    logic [SLOT_W:0] r_cnt;

    logic       r_rd;
    logic       r_tbl_pend;
    logic [6:0] r_tbl_slot;
    logic       r_res, r_drop, r_ev;
    logic [2:0] r_reason;
    logic [6:0] r_hs;
    logic [7:0] r_ttl;

    assign w_acc = start && !busy;
    assign w_op  = t_op'(i_op);

    sttl_parser u_parser (
        .i_clk, .i_rst_n,
        .i_en   (w_acc && w_op == OP_BYTE),
        .i_byte (i_data_byte),
        .i_last (i_last_byte),
        .o_etype(p_etype), .o_ihl(p_ihl), .o_proto(p_proto), .o_hop(p_hop),
        .o_high (p_high), .o_low(p_low), .o_port(p_port), .o_flags(p_flags)
    );

    // verdict before the table lookup
    logic       w_pre_done, w_pre_drop, w_need;
    logic [2:0] w_pre_rsn;
    logic [63:0] w_kh, w_kl;
    always_comb begin
        w_pre_done = 1'b1; w_pre_drop = 1'b0; w_pre_rsn = RSN_NOT_TCPIP;
        w_need = 1'b0; w_kh = p_high; w_kl = p_low;
        if ((p_etype == ETH_IPV4 || p_etype == ETH_IPV6) && p_proto == PROTO_TCP) begin
            if (p_etype == ETH_IPV4 && p_ihl < 4'd5) begin
                w_pre_drop = 1'b1; w_pre_rsn = RSN_BAD_IHL;
            end else if (!(p_flags[1] && p_flags[4])) begin
                w_pre_rsn = RSN_NOT_SYNACK;
            end else begin
                w_pre_done = 1'b0; w_need = 1'b1;
            end
            if (p_etype == ETH_IPV4) begin
                w_kh = '0;
                w_kl = {32'h0000ffff, p_low[31:0]};
            end
        end
    end

    logic w_search_go;
    assign w_search_go = w_acc && w_op == OP_BYTE && i_last_byte && w_need;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (w_search_go) n_state = ST_SEARCH;
            ST_SEARCH: if (r_cnt == (SLOT_W+1)'(TABLE_ENTRIES)) n_state = ST_DONE;
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy = (r_state != ST_IDLE) || r_tbl_pend;
    end

    assign w_tok[0] = '{active: (r_state == ST_IDLE) && w_search_go, found: 1'b0,
                        slot: '0};

    logic w_wr;
    assign w_wr = w_acc && w_op == OP_WRITE && {1'b0, i_slot} < 8'(TABLE_ENTRIES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt <= '0;
            r_cmd.wr <= 1'b0;
            r_cmd.rec <= 1'b0;
            r_tbl_pend <= 1'b0;
            r_res <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cmd.wr  <= w_wr;
            r_cmd.rec <= 1'b0;
            r_res <= 1'b0;
            r_tbl_pend <= w_acc && (w_op == OP_WRITE || w_op == OP_READ);
            if (r_state == ST_IDLE) r_cnt <= '0;
            else if (r_state == ST_SEARCH) r_cnt <= r_cnt + 1'b1;
            if (w_acc && w_op == OP_BYTE && i_last_byte && w_pre_done) begin
                r_res <= 1'b1;
                r_drop <= w_pre_drop; r_reason <= w_pre_rsn;
                r_hs <= '0; r_ttl <= '0; r_ev <= 1'b0;
            end
            if (r_tbl_pend) begin
                r_res <= 1'b1;
                r_drop <= 1'b0; r_reason <= RSN_TABLE_OP; r_hs <= r_tbl_slot;
                if ({1'b0, r_tbl_slot} < 8'(TABLE_ENTRIES)) begin
                    // a write reports the valid bit it is putting in place
                    r_ev  <= r_rd ? w_cv[r_tbl_slot] : r_cmd.wr_valid;
                    r_ttl <= (r_rd && w_cv[r_tbl_slot]) ? w_ct[r_tbl_slot] : 8'd0;
                end else begin
                    r_ev <= 1'b0; r_ttl <= 8'd0;
                end
            end
            if (r_state == ST_SEARCH && r_cnt == (SLOT_W+1)'(TABLE_ENTRIES)) begin
                r_res <= 1'b1; r_ev <= 1'b0;
                if (w_tok[TABLE_ENTRIES].found) begin
                    r_drop <= 1'b1; r_reason <= RSN_RECORDED;
                    r_hs <= w_tok[TABLE_ENTRIES].slot; r_ttl <= r_cmd.rec_ttl;
                    r_cmd.rec <= 1'b1;
                    r_cmd.rec_slot <= w_tok[TABLE_ENTRIES].slot;
                end else begin
                    r_drop <= 1'b0; r_reason <= RSN_NO_MATCH;
                    r_hs <= '0; r_ttl <= '0;
                end
            end
        end
        r_cmd.wr_slot  <= i_slot;
        r_cmd.wr_valid <= i_install;
        r_cmd.wr_high  <= i_addr_high;
        r_cmd.wr_low   <= i_addr_low;
        r_cmd.wr_port  <= i_port;
        if (w_acc) begin
            r_tbl_slot <= i_slot;
            r_rd       <= (w_op == OP_READ);
        end
        if (w_search_go && r_state == ST_IDLE) begin
            r_cmd.key_high <= w_kh;
            r_cmd.key_low  <= w_kl;
            r_cmd.key_port <= p_port;
            r_cmd.rec_ttl  <= p_hop;
        end
    end

    // token start is delayed by one register stage, r_tok0, so that it enters
    // the chain together with the key captured in r_cmd
    t_tok r_tok0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_tok0 <= '0;
        else r_tok0 <= w_tok[0];
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            sttl_cell u_cell (
                .i_clk, .i_rst_n,
                .i_index (SLOT_W'(g)),
                .i_cmd   (r_cmd),
                .i_tok   (g == 0 ? r_tok0 : w_tok[g]),
                .o_tok   (w_tok[g+1]),
                .o_valid (w_cv[g]),
                .o_ttl   (w_ct[g])
            );
        end
    endgenerate

    assign o_strobe      = r_res;
    assign o_drop        = r_drop;
    assign o_reason      = r_reason;
    assign o_hit_slot    = r_hs;
    assign o_ttl         = r_ttl;
    assign o_entry_valid = r_ev;

    a_busy_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SEARCH |-> busy) else $error("search not busy");
    a_rec_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_reason == RSN_RECORDED |-> o_drop) else $error("recorded kept");
    a_tbl_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_reason == RSN_TABLE_OP |-> !o_drop) else $error("table op drop");
    a_one_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tbl_pend |=> o_strobe) else $error("table op lost");
endmodule

FILE: sim/tb_synack_ttl_flow_recorder_unit.sv
`timescale 1ns / 1ps

module tb_synack_ttl_flow_recorder_unit;
    import sttl_pkg::*;

    // one command transfer
    typedef struct {
        t_op         op;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [6:0]  slot;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [15:0] port;
        logic        install;
    } t_cmd_item;

    // one verdict or table answer
    typedef struct {
        logic       drop;
        logic [2:0] reason;
        logic [6:0] hit_slot;
        logic [7:0] ttl;
        logic       entry_valid;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_op;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic [6:0]  i_slot;
    logic [63:0] i_addr_high;
    logic [63:0] i_addr_low;
    logic [15:0] i_port;
    logic        i_install;
    logic        o_strobe;
    logic        o_drop;
    logic [2:0]  o_reason;
    logic [6:0]  o_hit_slot;
    logic [7:0]  o_ttl;
    logic        o_entry_valid;

    synack_ttl_flow_recorder_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_op(i_op), .i_data_byte(i_data_byte), .i_last_byte(i_last_byte),
        .i_slot(i_slot), .i_addr_high(i_addr_high), .i_addr_low(i_addr_low),
        .i_port(i_port), .i_install(i_install), .o_strobe(o_strobe),
        .o_drop(o_drop), .o_reason(o_reason), .o_hit_slot(o_hit_slot),
        .o_ttl(o_ttl), .o_entry_valid(o_entry_valid)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    t_cmd_item pending_cmds[$];
    t_answer   expected_answers[$];
    int        error_count;
    int        cycle_count;
    bit        stimulus_done;

    // ---------------------------------------------------------------
    // Predictor state: frame parser plus flow table
    // ---------------------------------------------------------------
    logic [7:0]  pos;
    logic [15:0] etype;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [7:0]  hop;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [15:0] frm_port;
    logic [7:0]  flags;
    logic        tbl_valid[TABLE_ENTRIES];
    logic [63:0] tbl_high[TABLE_ENTRIES];
    logic [63:0] tbl_low[TABLE_ENTRIES];
    logic [15:0] tbl_port[TABLE_ENTRIES];
    logic [7:0]  tbl_ttl[TABLE_ENTRIES];

    // flows installed so far, used to aim SYN+ACK frames at the table
    logic [63:0] known_high[$];
    logic [63:0] known_low[$];
    logic [15:0] known_port[$];

    task automatic clear_frame_state();
        pos = '0; etype = '0; ihl = '0; proto = '0; hop = '0;
        src_hi = '0; src_lo = '0; frm_port = '0; flags = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b);
        int  p;
        int  tcp_at;
        bit  has_tcp;
        p = int'(pos);
        tcp_at = 0;
        has_tcp = 0;
        if (p == 12) etype = {b, 8'h00};
        if (p == 13) etype = {etype[15:8], b};
        if (etype == ETH_IPV4 && p >= 14) begin
            if (p == 14) ihl = b[3:0];
            if (p == 22) hop = b;
            if (p == 23) proto = b;
            if (p >= 26 && p <= 29) src_lo[8*(29-p) +: 8] = b;
            if (p > 14 && ihl >= 4'd5) begin
                tcp_at = 14 + 4 * int'(ihl);
                has_tcp = 1;
            end
        end else if (etype == ETH_IPV6 && p >= 14) begin
            if (p == 20) proto = b;
            if (p == 21) hop = b;
            if (p >= 22 && p <= 29) src_hi[8*(29-p) +: 8] = b;
            if (p >= 30 && p <= 37) src_lo[8*(37-p) +: 8] = b;
            tcp_at = int'(V6_TCP_START);
            has_tcp = 1;
        end
        if (has_tcp && p >= tcp_at) begin
            if (p - tcp_at == 0) frm_port = {b, 8'h00};
            if (p - tcp_at == 1) frm_port = {frm_port[15:8], b};
            if (p - tcp_at == 13) flags = b;
        end
        if (pos != 8'hff) pos = pos + 8'd1;
    endtask

    function automatic t_answer frame_verdict();
        t_answer a;
        logic [63:0] kh;
        logic [63:0] kl;
        a = '{default: '0};
        if (etype == ETH_IPV4) begin
            if (proto != PROTO_TCP) return a;
            if (ihl < 4'd5) begin
                a.drop = 1'b1; a.reason = RSN_BAD_IHL;
                return a;
            end
            kh = '0;
            kl = {32'h0000ffff, src_lo[31:0]};
        end else if (etype == ETH_IPV6) begin
            if (proto != PROTO_TCP) return a;
            kh = src_hi;
            kl = src_lo;
        end else begin
            return a;
        end
        if (!(flags[1] && flags[4])) begin
            a.reason = RSN_NOT_SYNACK;
            return a;
        end
        // lowest matching slot wins
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_high[i] == kh && tbl_low[i] == kl &&
                tbl_port[i] == frm_port) begin
                tbl_ttl[i] = hop;
                a.drop = 1'b1; a.reason = RSN_RECORDED;
                a.hit_slot = 7'(i); a.ttl = hop;
                return a;
            end
        end
        a.reason = RSN_NO_MATCH;
        return a;
    endfunction

    // run one accepted transfer through the predictor
    task automatic predict_transfer(input t_cmd_item c);
        t_answer a;
        a = '{default: '0};
        case (c.op)
            OP_BYTE: begin
                parse_byte(c.data_byte);
                if (c.last_byte) begin
                    expected_answers.push_back(frame_verdict());
                    clear_frame_state();
                end
            end
            OP_WRITE: begin
                tbl_valid[c.slot] = c.install;
                tbl_high[c.slot]  = c.addr_high;
                tbl_low[c.slot]   = c.addr_low;
                tbl_port[c.slot]  = c.port;
                tbl_ttl[c.slot]   = '0;
                a.reason = RSN_TABLE_OP; a.hit_slot = c.slot;
                a.entry_valid = c.install;
                expected_answers.push_back(a);
            end
            OP_READ: begin
                a.reason = RSN_TABLE_OP; a.hit_slot = c.slot;
                if (tbl_valid[c.slot]) begin
                    a.ttl = tbl_ttl[c.slot];
                    a.entry_valid = 1'b1;
                end
                expected_answers.push_back(a);
            end
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------
    // Stimulus builders
    // ---------------------------------------------------------------
    int frame_count;

    function automatic t_cmd_item blank_cmd();
        t_cmd_item c;
        c.op = OP_BYTE; c.data_byte = '0; c.last_byte = 1'b0; c.slot = '0;
        c.addr_high = {$urandom, $urandom}; c.addr_low = {$urandom, $urandom};
        c.port = 16'($urandom); c.install = 1'($urandom);
        return c;
    endfunction

    task automatic push_table_write(input logic [6:0] s, input logic inst,
                                    input logic [63:0] hi, input logic [63:0] lo,
                                    input logic [15:0] pt);
        t_cmd_item c;
        c = blank_cmd();
        c.op = OP_WRITE; c.slot = s; c.install = inst;
        c.addr_high = hi; c.addr_low = lo; c.port = pt;
        pending_cmds.push_back(c);
        if (inst) begin
            known_high.push_back(hi); known_low.push_back(lo); known_port.push_back(pt);
        end
    endtask

    task automatic push_table_read(input logic [6:0] s);
        t_cmd_item c;
        c = blank_cmd();
        c.op = OP_READ; c.slot = s;
        pending_cmds.push_back(c);
    endtask

    // frame bytes, optionally interleaved with table ops and unused op codes
    task automatic push_frame(input logic [7:0] bytes[$], input bit noisy);
        t_cmd_item c;
        for (int i = 0; i < bytes.size(); i++) begin
            if (noisy && $urandom_range(0, 15) == 0) begin
                c = blank_cmd();
                c.op = $urandom_range(0, 1) ? OP_READ : OP_NONE;
                c.slot = 7'($urandom);
                pending_cmds.push_back(c);
            end
            c = blank_cmd();
            c.op = OP_BYTE;
            c.data_byte = bytes[i];
            c.last_byte = (i == bytes.size() - 1);
            pending_cmds.push_back(c);
        end
        frame_count++;
    endtask

    // builds a TCP frame; cut trims it short, ihl only matters for IPv4
    task automatic build_tcp_frame(input bit v6, input logic [63:0] hi,
                                   input logic [63:0] lo, input logic [15:0] pt,
                                   input logic [7:0] fl, input logic [7:0] hl,
                                   input logic [3:0] hdr_words, input logic [7:0] pr,
                                   input int cut, input bit noisy);
        logic [7:0] f[$];
        int tcp_at;
        int total;
        for (int i = 0; i < 12; i++) f.push_back(8'($urandom));
        if (v6) begin
            f.push_back(8'h86); f.push_back(8'hdd);
            for (int i = 14; i < 20; i++) f.push_back(8'($urandom));
            f.push_back(pr); f.push_back(hl);
            for (int i = 0; i < 8; i++) f.push_back(hi[8*(7-i) +: 8]);
            for (int i = 0; i < 8; i++) f.push_back(lo[8*(7-i) +: 8]);
            tcp_at = 54;
        end else begin
            f.push_back(8'h08); f.push_back(8'h00);
            f.push_back({4'h4, hdr_words});
            for (int i = 15; i < 22; i++) f.push_back(8'($urandom));
            f.push_back(hl); f.push_back(pr);
            f.push_back(8'($urandom)); f.push_back(8'($urandom));
            for (int i = 0; i < 4; i++) f.push_back(lo[8*(3-i) +: 8]);
            tcp_at = (hdr_words >= 4'd5) ? 14 + 4 * int'(hdr_words) : 34;
        end
        while (f.size() < tcp_at) f.push_back(8'($urandom));
        f.push_back(pt[15:8]); f.push_back(pt[7:0]);
        for (int i = 2; i < 13; i++) f.push_back(8'($urandom));
        f.push_back(fl);
        total = f.size() + $urandom_range(0, 8);
        while (f.size() < total) f.push_back(8'($urandom));
        if (cut > 0 && cut < f.size()) f = f[0:cut-1];
        push_frame(f, noisy);
    endtask

    task automatic random_garbage_frame(input int len);
        logic [7:0] f[$];
        for (int i = 0; i < len; i++) f.push_back(8'($urandom));
        push_frame(f, 1);
    endtask

    // a random frame, mostly a TCP SYN+ACK aimed at a known flow
    task automatic random_tcp_frame();
        logic [63:0] hi;
        logic [63:0] lo;
        logic [15:0] pt;
        logic [7:0]  fl;
        bit v6;
        int k;
        hi = {$urandom, $urandom}; lo = {$urandom, $urandom}; pt = 16'($urandom);
        v6 = 1'($urandom_range(0, 1));
        if (known_high.size() > 0 && $urandom_range(0, 3) != 0) begin
            k = $urandom_range(0, known_high.size() - 1);
            hi = known_high[k]; lo = known_low[k]; pt = known_port[k];
            v6 = !(hi == 0 && lo[63:32] == 32'h0000ffff);
        end
        fl = 8'($urandom);
        if ($urandom_range(0, 4) != 0) fl = fl | 8'h12;
        build_tcp_frame(v6, hi, lo, pt, fl, 8'($urandom),
                        ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(5, 15)),
                        ($urandom_range(0, 9) == 0) ? 8'($urandom) : PROTO_TCP,
                        ($urandom_range(0, 12) == 0) ? $urandom_range(1, 60) : 0, 1);
    endtask

    task automatic random_table_op();
        logic [63:0] hi;
        logic [63:0] lo;
        if ($urandom_range(0, 1)) begin
            if ($urandom_range(0, 1)) begin
                hi = '0; lo = {32'h0000ffff, $urandom};
            end else begin
                hi = {$urandom, $urandom}; lo = {$urandom, $urandom};
            end
            push_table_write(7'($urandom), $urandom_range(0, 4) != 0, hi, lo,
                             16'($urandom));
        end else begin
            push_table_read(7'($urandom));
        end
    endtask

    initial begin
        logic [7:0] long_frame[$];
        error_count = 0;
        frame_count = 0;
        clear_frame_state();
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_valid[i] = 1'b0; tbl_high[i] = '0; tbl_low[i] = '0;
            tbl_port[i] = '0; tbl_ttl[i] = '0;
        end

        // directed: table extremes, duplicates, every verdict reason
        push_table_write(7'd0, 1, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 16'hffff);
        push_table_write(7'd127, 1, 64'h0, {32'h0000ffff, 32'hc0a8_0101}, 16'd443);
        push_table_write(7'd5, 1, 64'h0, {32'h0000ffff, 32'hc0a8_0101}, 16'd443);
        push_table_write(7'd9, 1, 64'h2001_0db8_0000_0001, 64'h0, 16'h0);
        push_table_read(7'd0);
        push_table_read(7'd64);
        build_tcp_frame(0, 0, {32'h0000ffff, 32'hc0a8_0101}, 16'd443, 8'h12, 8'd64,
                        4'd5, PROTO_TCP, 0, 0);       // duplicate flows, lowest wins
        build_tcp_frame(1, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 16'hffff,
                        8'hff, 8'd255, 4'd5, PROTO_TCP, 0, 0);
        build_tcp_frame(1, 64'h2001_0db8_0000_0001, 64'h0, 16'h0, 8'h12, 8'd0,
                        4'd5, PROTO_TCP, 0, 0);
        build_tcp_frame(0, 0, 64'h1, 16'd80, 8'h12, 8'd1, 4'd15, PROTO_TCP, 0, 0);
        build_tcp_frame(0, 0, 64'h1, 16'd80, 8'h12, 8'd1, 4'd3, PROTO_TCP, 0, 0);  // bad ihl
        build_tcp_frame(0, 0, 64'h1, 16'd80, 8'h12, 8'd1, 4'd3, 8'd17, 0, 0);     // bad ihl, udp
        build_tcp_frame(1, 64'h1, 64'h2, 16'd80, 8'h02, 8'd9, 4'd5, PROTO_TCP, 0, 0);
        build_tcp_frame(0, 0, {32'h0000ffff, 32'hc0a8_0101}, 16'd443, 8'h12, 8'd7,
                        4'd5, PROTO_TCP, 30, 0);      // short frame
        random_garbage_frame(1);
        for (int i = 0; i < 300; i++) long_frame.push_back(8'($urandom));
        push_frame(long_frame, 0);                    // long frame, position saturates
        push_table_read(7'd5);
        push_table_read(7'd127);
        push_table_write(7'd5, 0, 64'h0, 64'h0, 16'h0);
        push_table_read(7'd5);

        // random: mostly well-formed SYN+ACK traffic against a busy table
        for (int i = 0; i < 40; i++) random_table_op();
        while (pending_cmds.size() < 1950) begin
            case ($urandom_range(0, 9))
                0, 1:    random_table_op();
                2:       random_garbage_frame($urandom_range(1, 40));
                default: random_tcp_frame();
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Driver: one transfer per handshake, random gap after each
    // ---------------------------------------------------------------
    int gap_left;
    t_cmd_item drive_copy;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left <= $urandom_range(0, 9);
        end else if (start && busy) begin
            // hold until accepted
        end else begin
            if (start) predict_transfer(drive_copy);
            if (pending_cmds.size() == 0) begin
                start <= 1'b0;
                if (!start) stimulus_done <= 1'b1;
            end else if (gap_left > 0 && (!start || $urandom_range(0, 1))) begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end else begin
                drive_copy = pending_cmds.pop_front();
                start       <= 1'b1;
                i_op        <= drive_copy.op;
                i_data_byte <= drive_copy.data_byte;
                i_last_byte <= drive_copy.last_byte;
                i_slot      <= drive_copy.slot;
                i_addr_high <= drive_copy.addr_high;
                i_addr_low  <= drive_copy.addr_low;
                i_port      <= drive_copy.port;
                i_install   <= drive_copy.install;
                // stretches with no gaps at all now and then
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: every strobe must match the oldest expectation
    // ---------------------------------------------------------------
    t_answer want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_answers.size() == 0) begin
                $display("%0t: unexpected result drop=%0d reason=%0d slot=%0d ttl=%0d valid=%0d",
                         $time, o_drop, o_reason, o_hit_slot, o_ttl, o_entry_valid);
                error_count++;
            end else begin
                want = expected_answers.pop_front();
                if (o_drop !== want.drop) begin
                    $display("%0t: drop expected %0d actual %0d", $time, want.drop, o_drop);
                    error_count++;
                end
                if (o_reason !== want.reason) begin
                    $display("%0t: reason expected %0d actual %0d", $time, want.reason,
                             o_reason);
                    error_count++;
                end
                if (o_hit_slot !== want.hit_slot) begin
                    $display("%0t: hit_slot expected %0d actual %0d", $time, want.hit_slot,
                             o_hit_slot);
                    error_count++;
                end
                if (o_ttl !== want.ttl) begin
                    $display("%0t: ttl expected %0d actual %0d", $time, want.ttl, o_ttl);
                    error_count++;
                end
                if (o_entry_valid !== want.entry_valid) begin
                    $display("%0t: entry_valid expected %0d actual %0d", $time,
                             want.entry_valid, o_entry_valid);
                    error_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Reset, drain and run limit
    // ---------------------------------------------------------------
    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        stimulus_done = 1'b0;
        i_op = OP_BYTE; i_data_byte = '0; i_last_byte = 1'b0; i_slot = '0;
        i_addr_high = '0; i_addr_low = '0; i_port = '0; i_install = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stimulus_done && expected_answers.size() == 0);
        // room for a straggling result after the last expected one
        repeat (2 * TABLE_ENTRIES + 10) @(posedge i_clk);
        if (error_count == 0 && expected_answers.size() == 0) begin
            $display("synack_ttl_flow_recorder_unit verification clean");
        end else begin
            $display("synack_ttl_flow_recorder_unit verification failed");
        end
        $finish;
    end

    // each item costs its busy time plus a random gap
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2_000_000) begin
            $display("synack_ttl_flow_recorder_unit verification failed");
            $finish;
        end
    end

    initial cycle_count = 0;

endmodule
